// File: rtl/dcac_pkg.sv
// Shared constants, codes and types of the drawing-context cache.
// Used by dcac_core and drawing_context_assoc_cache; no dependencies.
package dcac_pkg;

    localparam int NUM_SETS     = 16;
    localparam int NUM_WAYS     = 8;
    localparam int NUM_CONTEXTS = 128;
    localparam int SLOT_COUNT   = NUM_SETS * NUM_WAYS;

    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CTX_W  = $clog2(NUM_CONTEXTS);

    // key / NUM_SETS as a reciprocal multiply, exact for 8-bit keys
    localparam int SET_RECIP = (65536 + NUM_SETS - 1) / NUM_SETS;

    localparam logic [1:0] OP_FIND    = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_PURGE   = 2'd2;

    localparam logic [2:0] ST_HIT    = 3'd0;
    localparam logic [2:0] ST_NEW    = 3'd1;
    localparam logic [2:0] ST_REUSE  = 3'd2;
    localparam logic [2:0] ST_CFAULT = 3'd3;
    localparam logic [2:0] ST_XFAULT = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CTX_W-1:0]  t_ctx;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] pixel;
        logic [7:0]  key;
        logic [3:0]  screen;
        logic [3:0]  fn;
        logic        sw;
        logic [31:0] font;
        logic [6:0]  handle;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] item;
        logic [6:0] ctx;
        logic       load_all;
        logic       load_font;
    } t_res;

    typedef struct packed {
        t_slot       slot;
        t_ctx        cx;
        logic [15:0] refs;
        logic [31:0] hits;
    } t_tab_ent;

    typedef struct packed {
        logic [3:0]  screen;
        logic [31:0] pixel;
        logic [3:0]  fn;
        logic        sw;
        logic [31:0] font;
    } t_ctx_ent;

    function automatic logic [SET_W-1:0] set_of(input logic [7:0] key);
        logic [24:0] prod;
        logic [7:0]  q;
        logic [16:0] qm;
        logic [16:0] rem;
        prod = 25'(key) * 25'(SET_RECIP);
        q    = prod[23:16];
        qm   = 17'(q) * 17'(NUM_SETS);
        rem  = 17'(key) - qm;
        return SET_W'(rem);
    endfunction

endpackage

// File: rtl/dcac_core.sv
// Sequencer of the cache: slot/item table memory, context pool memory and
// the find, release and purge walks. Depends on dcac_pkg.
module dcac_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  dcac_pkg::t_req  i_req,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output dcac_pkg::t_res  o_res
);
    import dcac_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SLOT_RD = 4'd1;
    localparam logic [3:0] S_SLOT_WT = 4'd2;
    localparam logic [3:0] S_ITEM_WT = 4'd3;
    localparam logic [3:0] S_CTX_WT  = 4'd4;
    localparam logic [3:0] S_PV_RD   = 4'd5;
    localparam logic [3:0] S_PV_SLOT = 4'd6;
    localparam logic [3:0] S_PV_ITEM = 4'd7;
    localparam logic [3:0] S_SWAP    = 4'd8;
    localparam logic [3:0] S_POOL_RD = 4'd9;
    localparam logic [3:0] S_POOL_EV = 4'd10;
    localparam logic [3:0] S_REL_RD  = 4'd11;
    localparam logic [3:0] S_REL_EV  = 4'd12;
    localparam logic [3:0] S_PUR_RD  = 4'd13;
    localparam logic [3:0] S_PUR_EV  = 4'd14;
    localparam logic [3:0] S_DONE    = 4'd15;

    logic [3:0]       r_state, n_state;
    t_req             r_req, n_req;
    logic [SET_W-1:0] r_set, n_set;
    logic [WAY_W-1:0] r_way, n_way;
    t_slot            r_it, n_it;
    t_slot            r_pv, n_pv;
    t_slot            r_si, n_si;
    t_ctx             r_cx, n_cx;
    t_ctx             r_pi, n_pi;
    logic [15:0]      r_refs, n_refs;
    logic [31:0]      r_hits, n_hits;
    t_res             r_res, n_res;

    logic [SLOT_COUNT-1:0]   r_slot_vld, n_slot_vld;
    logic [SLOT_COUNT-1:0]   r_item_wr, n_item_wr;
    logic [SLOT_COUNT-1:0]   r_bound, n_bound;
    logic [NUM_CONTEXTS-1:0] r_created, n_created;
    logic [NUM_CONTEXTS-1:0] r_in_use, n_in_use;

    // table memory: slot lane and item lane share one port
    t_tab_ent tab_mem [SLOT_COUNT];
    t_tab_ent tab_q, tab_wd;
    t_slot    tab_addr, r_tab_ra;
    logic     tab_re, tab_we_slot, tab_we_item;

    t_ctx_ent ctx_mem [NUM_CONTEXTS];
    t_ctx_ent ctx_q, ctx_wd;
    t_ctx     ctx_addr;
    logic     ctx_re, ctx_we;

    always_ff @(posedge i_clk) begin
        if (tab_we_slot) tab_mem[tab_addr].slot <= tab_wd.slot;
        if (tab_we_item) begin
            tab_mem[tab_addr].cx   <= tab_wd.cx;
            tab_mem[tab_addr].refs <= tab_wd.refs;
            tab_mem[tab_addr].hits <= tab_wd.hits;
        end
        if (tab_re) begin
            tab_q    <= tab_mem[tab_addr];
            r_tab_ra <= tab_addr;
        end
        if (ctx_we) ctx_mem[ctx_addr] <= ctx_wd;
        if (ctx_re) ctx_q <= ctx_mem[ctx_addr];
    end

    // unwritten entries read as their reset values
    t_slot       slot_rd;
    logic [15:0] refs_rd;
    logic [31:0] hits_rd;
    assign slot_rd = r_slot_vld[r_tab_ra] ? tab_q.slot : r_tab_ra;
    assign refs_rd = r_item_wr[r_tab_ra] ? tab_q.refs : 16'd0;
    assign hits_rd = r_item_wr[r_tab_ra] ? tab_q.hits : 32'd0;

    logic        match, lf;
    logic [15:0] refs_inc;
    logic [31:0] hits_inc;
    t_ctx_ent    load_ent;

    assign match = ctx_q.pixel == r_req.pixel && ctx_q.fn == r_req.fn &&
                   ctx_q.sw == r_req.sw && ctx_q.screen == r_req.screen;
    assign lf = r_req.font != 32'd0 && r_req.font != ctx_q.font;
    assign refs_inc = (r_refs == 16'hFFFF) ? r_refs : r_refs + 16'd1;
    assign hits_inc = (r_hits == 32'hFFFF_FFFF) ? r_hits : r_hits + 32'd1;
    assign load_ent = '{screen: r_req.screen, pixel: r_req.pixel, fn: r_req.fn,
                        sw: r_req.sw, font: r_req.font};

    always_comb begin
        n_state = r_state;
        n_req = r_req;
        n_set = r_set;
        n_way = r_way;
        n_it = r_it;
        n_pv = r_pv;
        n_si = r_si;
        n_cx = r_cx;
        n_pi = r_pi;
        n_refs = r_refs;
        n_hits = r_hits;
        n_res = r_res;
        n_slot_vld = r_slot_vld;
        n_item_wr = r_item_wr;
        n_bound = r_bound;
        n_created = r_created;
        n_in_use = r_in_use;
        tab_re = 1'b0;
        tab_we_slot = 1'b0;
        tab_we_item = 1'b0;
        tab_addr = '0;
        tab_wd = '0;
        ctx_re = 1'b0;
        ctx_we = 1'b0;
        ctx_addr = '0;
        ctx_wd = load_ent;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req = i_req;
                    n_set = set_of(i_req.key);
                    n_way = '0;
                    n_si = '0;
                    n_res = '{status: ST_DONE, item: 7'd0, ctx: 7'd0,
                              load_all: 1'b0, load_font: 1'b0};
                    case (i_req.op)
                        OP_FIND:    n_state = S_SLOT_RD;
                        OP_RELEASE: n_state = S_REL_RD;
                        OP_PURGE:   n_state = S_PUR_RD;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SLOT_RD: begin
                tab_re = 1'b1;
                tab_addr = {r_set, r_way};
                n_state = S_SLOT_WT;
            end
            S_SLOT_WT: begin
                n_it = slot_rd;
                tab_re = 1'b1;
                tab_addr = slot_rd;
                n_state = S_ITEM_WT;
            end
            S_ITEM_WT: begin
                n_refs = refs_rd;
                n_hits = hits_rd;
                n_cx = tab_q.cx;
                if (!r_bound[r_it]) begin
                    n_pi = '0;
                    n_state = S_POOL_RD;
                end else begin
                    ctx_re = 1'b1;
                    ctx_addr = tab_q.cx;
                    n_state = S_CTX_WT;
                end
            end
            S_CTX_WT: begin
                if (match) begin
                    if (lf) begin
                        ctx_we = 1'b1;
                        ctx_addr = r_cx;
                        ctx_wd = ctx_q;
                        ctx_wd.font = r_req.font;
                    end
                    tab_we_item = 1'b1;
                    tab_addr = r_it;
                    tab_wd = '{slot: '0, cx: r_cx, refs: refs_inc, hits: hits_inc};
                    n_item_wr[r_it] = 1'b1;
                    n_hits = hits_inc;
                    n_res = '{status: ST_HIT, item: 7'(r_it), ctx: 7'(r_cx),
                              load_all: 1'b0, load_font: lf};
                    n_state = (r_way != '0) ? S_PV_RD : S_DONE;
                end else if (r_way == WAY_W'(NUM_WAYS - 1)) begin
                    if (r_refs == 16'd0 && ctx_q.screen == r_req.screen) begin
                        ctx_we = 1'b1;
                        ctx_addr = r_cx;
                        n_in_use[r_cx] = 1'b1;
                        tab_we_item = 1'b1;
                        tab_addr = r_it;
                        tab_wd = '{slot: '0, cx: r_cx, refs: 16'd1, hits: 32'd1};
                        n_item_wr[r_it] = 1'b1;
                        n_res = '{status: ST_REUSE, item: 7'(r_it), ctx: 7'(r_cx),
                                  load_all: 1'b1, load_font: 1'b0};
                    end else begin
                        n_res = '{status: ST_CFAULT, item: 7'(r_it), ctx: 7'd0,
                                  load_all: 1'b0, load_font: 1'b0};
                    end
                    n_state = S_DONE;
                end else begin
                    n_way = r_way + 1'b1;
                    n_state = S_SLOT_RD;
                end
            end
            S_PV_RD: begin
                tab_re = 1'b1;
                tab_addr = {r_set, WAY_W'(r_way - 1'b1)};
                n_state = S_PV_SLOT;
            end
            S_PV_SLOT: begin
                n_pv = slot_rd;
                tab_re = 1'b1;
                tab_addr = slot_rd;
                n_state = S_PV_ITEM;
            end
            S_PV_ITEM: begin
                if (r_hits > hits_rd) begin
                    tab_we_slot = 1'b1;
                    tab_addr = {r_set, r_way};
                    tab_wd.slot = r_pv;
                    n_slot_vld[{r_set, r_way}] = 1'b1;
                    n_state = S_SWAP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SWAP: begin
                tab_we_slot = 1'b1;
                tab_addr = {r_set, WAY_W'(r_way - 1'b1)};
                tab_wd.slot = r_it;
                n_slot_vld[{r_set, WAY_W'(r_way - 1'b1)}] = 1'b1;
                n_state = S_DONE;
            end
            S_POOL_RD: begin
                ctx_re = 1'b1;
                ctx_addr = r_pi;
                n_state = S_POOL_EV;
            end
            S_POOL_EV: begin
                // an uncreated context is created for this screen and taken at once
                if (!r_created[r_pi] ||
                    (!r_in_use[r_pi] && ctx_q.screen == r_req.screen)) begin
                    ctx_we = 1'b1;
                    ctx_addr = r_pi;
                    n_created[r_pi] = 1'b1;
                    n_in_use[r_pi] = 1'b1;
                    tab_we_item = 1'b1;
                    tab_addr = r_it;
                    tab_wd = '{slot: '0, cx: r_pi, refs: 16'd1, hits: 32'd1};
                    n_item_wr[r_it] = 1'b1;
                    n_bound[r_it] = 1'b1;
                    n_res = '{status: ST_NEW, item: 7'(r_it), ctx: 7'(r_pi),
                              load_all: 1'b1, load_font: 1'b0};
                    n_state = S_DONE;
                end else if (r_pi == CTX_W'(NUM_CONTEXTS - 1)) begin
                    n_res = '{status: ST_XFAULT, item: 7'(r_it), ctx: 7'd0,
                              load_all: 1'b0, load_font: 1'b0};
                    n_state = S_DONE;
                end else begin
                    n_pi = r_pi + 1'b1;
                    n_state = S_POOL_RD;
                end
            end
            S_REL_RD: begin
                n_res.item = r_req.handle;
                if (32'(r_req.handle) < SLOT_COUNT) begin
                    tab_re = 1'b1;
                    tab_addr = SLOT_W'(r_req.handle);
                    n_state = S_REL_EV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REL_EV: begin
                if (refs_rd != 16'd0) begin
                    tab_we_item = 1'b1;
                    tab_addr = r_tab_ra;
                    tab_wd = '{slot: '0, cx: tab_q.cx, refs: refs_rd - 16'd1,
                               hits: hits_rd};
                end
                n_state = S_DONE;
            end
            S_PUR_RD: begin
                tab_re = 1'b1;
                tab_addr = r_si;
                n_state = S_PUR_EV;
            end
            S_PUR_EV: begin
                if (r_bound[r_si] && refs_rd == 16'd0) begin
                    n_in_use[tab_q.cx] = 1'b0;
                    n_bound[r_si] = 1'b0;
                end
                if (r_si == SLOT_W'(SLOT_COUNT - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_si = r_si + 1'b1;
                    n_state = S_PUR_RD;
                end
            end
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot_vld <= '0;
            r_item_wr <= '0;
            r_bound <= '0;
            r_created <= '0;
            r_in_use <= '0;
        end else begin
            r_state <= n_state;
            r_slot_vld <= n_slot_vld;
            r_item_wr <= n_item_wr;
            r_bound <= n_bound;
            r_created <= n_created;
            r_in_use <= n_in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_set <= n_set;
        r_way <= n_way;
        r_it <= n_it;
        r_pv <= n_pv;
        r_si <= n_si;
        r_cx <= n_cx;
        r_pi <= n_pi;
        r_refs <= n_refs;
        r_hits <= n_hits;
        r_res <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res = r_res;

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> r_res.status <= ST_DONE)
        else $error("result status out of range");

    a_new_loads_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res.status == ST_NEW) |-> r_res.load_all && !r_res.load_font)
        else $error("new entry without full load");

    a_font_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res.load_font) |-> r_res.status == ST_HIT)
        else $error("font reload outside a hit");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req_valid) |=> r_state != S_IDLE)
        else $error("accepted item not started");

    a_bound_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITEM_WT && r_bound[r_it]) |-> r_item_wr[r_it])
        else $error("bound item never written");

endmodule

// File: rtl/drawing_context_assoc_cache.sv
// Find scans the ways of the set in order; a way with an unbound item walks the context pool
//   for a usable context; a hit past way 0 then checks the way before and swaps the two
//   when the hit item has more hits. Release reads one table entry; purge walks every entry.
// Throughput: one item at a time, set by the single table memory port and pool walk.
// A result register lets the next item be taken while a result waits.
// Reset (synchronous, active low) clears all valid, bound and pool flags at once.
// Top level of the drawing-context cache. Depends on dcac_pkg and dcac_core.
module drawing_context_assoc_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_pixel,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [3:0]  i_screen,
    input  logic [3:0]  i_raster_function,
    input  logic        i_subwindow_mode,
    input  logic [31:0] i_font_id,
    input  logic [6:0]  i_item_handle,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [6:0]  o_item_out,
    output logic [6:0]  o_context_index,
    output logic        o_load_all,
    output logic        o_load_font
);
    import dcac_pkg::*;

    t_req req;
    t_res res;
    t_res r_out;
    logic r_out_valid;
    logic req_ready;
    logic res_valid;
    logic res_ready;

    assign req = '{op: i_op, pixel: i_pixel, key: i_red ^ i_green ^ i_blue,
                   screen: i_screen, fn: i_raster_function, sw: i_subwindow_mode,
                   font: i_font_id, handle: i_item_handle};

    dcac_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign o_stall = !req_ready;
    assign res_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) r_out <= res;
    end

    assign o_valid = r_out_valid;
    assign o_status = r_out.status;
    assign o_item_out = r_out.item;
    assign o_context_index = r_out.ctx;
    assign o_load_all = r_out.load_all;
    assign o_load_font = r_out.load_font;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for drawing_context_assoc_cache.
// Holds a context-cache predictor and result scoreboard; depends on dcac_pkg and the RTL.
module testbench;
    import dcac_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] pixel;
        logic [7:0]  red, green, blue;
        logic [3:0]  screen;
        logic [3:0]  fn;
        logic        sw;
        logic [31:0] font;
        logic [6:0]  handle;
    } t_tb_req;

    typedef struct {
        logic [2:0] status;
        logic [6:0] item;
        logic [6:0] cx;
        logic       load_all;
        logic       load_font;
    } t_tb_res;

    int fail_count = 0;

    class ctx_cache_scoreboard;
        logic [6:0]  slot_item [SLOT_COUNT];
        bit          bound     [SLOT_COUNT];
        logic [6:0]  item_cx   [SLOT_COUNT];
        logic [15:0] refs      [SLOT_COUNT];
        logic [31:0] hits      [SLOT_COUNT];
        bit          created   [NUM_CONTEXTS];
        bit          in_use    [NUM_CONTEXTS];
        logic [3:0]  c_screen  [NUM_CONTEXTS];
        logic [31:0] c_pixel   [NUM_CONTEXTS];
        logic [3:0]  c_fn      [NUM_CONTEXTS];
        logic        c_sw      [NUM_CONTEXTS];
        logic [31:0] c_font    [NUM_CONTEXTS];
        t_tb_res     pending[$];

        function void clear();
            for (int s = 0; s < SLOT_COUNT; s++) begin
                slot_item[s] = 7'(s);
                bound[s] = 0;
                item_cx[s] = 0;
                refs[s] = 0;
                hits[s] = 0;
            end
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
                created[c] = 0;
                in_use[c] = 0;
                c_screen[c] = 0;
                c_pixel[c] = 0;
                c_fn[c] = 0;
                c_sw[c] = 0;
                c_font[c] = 0;
            end
            pending.delete();
        endfunction

        function t_tb_res find_ctx(t_tb_req r);
            t_tb_res o;
            int base, it, cx, i, pv;
            o = '{3'd0, 7'd0, 7'd0, 1'b0, 1'b0};
            base = (int'(r.red ^ r.green ^ r.blue) % NUM_SETS) * NUM_WAYS;
            for (int w = 0; w < NUM_WAYS; w++) begin
                it = slot_item[base + w];
                if (!bound[it]) begin
                    for (i = 0; i < NUM_CONTEXTS; i++) begin
                        if (!created[i]) begin
                            created[i] = 1;
                            in_use[i] = 0;
                            c_screen[i] = r.screen;
                        end
                        if (!in_use[i] && c_screen[i] == r.screen) break;
                    end
                    o.item = 7'(it);
                    if (i == NUM_CONTEXTS) begin
                        o.status = ST_XFAULT;
                        return o;
                    end
                    c_pixel[i] = r.pixel; c_fn[i] = r.fn; c_sw[i] = r.sw;
                    c_font[i] = r.font; in_use[i] = 1;
                    bound[it] = 1; item_cx[it] = 7'(i); refs[it] = 1; hits[it] = 1;
                    o.status = ST_NEW; o.cx = 7'(i); o.load_all = 1;
                    return o;
                end
                cx = item_cx[it];
                if (c_pixel[cx] == r.pixel && c_fn[cx] == r.fn && c_sw[cx] == r.sw &&
                    c_screen[cx] == r.screen) begin
                    if (r.font != 0 && r.font != c_font[cx]) begin
                        c_font[cx] = r.font;
                        o.load_font = 1;
                    end
                    if (refs[it] != 16'hFFFF) refs[it]++;
                    if (hits[it] != 32'hFFFF_FFFF) hits[it]++;
                    if (w > 0) begin
                        pv = slot_item[base + w - 1];
                        if (hits[it] > hits[pv]) begin
                            slot_item[base + w] = 7'(pv);
                            slot_item[base + w - 1] = 7'(it);
                        end
                    end
                    o.status = ST_HIT; o.item = 7'(it); o.cx = 7'(cx);
                    return o;
                end
            end
            it = slot_item[base + NUM_WAYS - 1];
            cx = item_cx[it];
            o.item = 7'(it);
            if (refs[it] == 0 && c_screen[cx] == r.screen) begin
                c_pixel[cx] = r.pixel; c_fn[cx] = r.fn; c_sw[cx] = r.sw;
                c_font[cx] = r.font; in_use[cx] = 1;
                refs[it] = 1; hits[it] = 1;
                o.status = ST_REUSE; o.cx = 7'(cx); o.load_all = 1;
                return o;
            end
            o.status = ST_CFAULT;
            return o;
        endfunction

        function void note_request(t_tb_req r);
            t_tb_res o;
            o = '{ST_DONE, 7'd0, 7'd0, 1'b0, 1'b0};
            if (r.op == OP_FIND) o = find_ctx(r);
            else if (r.op == OP_RELEASE) begin
                if (refs[r.handle] != 0) refs[r.handle]--;
                o.item = r.handle;
            end else if (r.op == OP_PURGE) begin
                for (int s = 0; s < SLOT_COUNT; s++)
                    if (bound[s] && refs[s] == 0) begin
                        in_use[item_cx[s]] = 0;
                        bound[s] = 0;
                    end
            end
            pending.push_back(o);
        endfunction

        function void check_result(t_tb_res a);
            t_tb_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d item %0d",
                         $time, a.status, a.item);
                fail_count++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
                fail_count++;
            end
            if (a.item !== e.item) begin
                $display("%0t: item expected %0d actual %0d", $time, e.item, a.item);
                fail_count++;
            end
            if (a.cx !== e.cx) begin
                $display("%0t: context expected %0d actual %0d", $time, e.cx, a.cx);
                fail_count++;
            end
            if (a.load_all !== e.load_all) begin
                $display("%0t: load_all expected %0d actual %0d", $time, e.load_all,
                         a.load_all);
                fail_count++;
            end
            if (a.load_font !== e.load_font) begin
                $display("%0t: load_font expected %0d actual %0d", $time, e.load_font,
                         a.load_font);
                fail_count++;
            end
        endfunction
    endclass

    logic        i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0;
    logic        o_stall, o_valid;
    logic [1:0]  i_op = 0;
    logic [31:0] i_pixel = 0, i_font_id = 0;
    logic [7:0]  i_red = 0, i_green = 0, i_blue = 0;
    logic [3:0]  i_screen = 0, i_raster_function = 0;
    logic        i_subwindow_mode = 0;
    logic [6:0]  i_item_handle = 0;
    logic [2:0]  o_status;
    logic [6:0]  o_item_out, o_context_index;
    logic        o_load_all, o_load_font;

    ctx_cache_scoreboard sb;
    bit      long_hold = 0;
    int      idle_cycles = 0;
    t_tb_req hot[$];

    drawing_context_assoc_cache u_dut (.*);

    always #10 i_clk = ~i_clk;

    // scoreboard updates and watchdog on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_request('{i_op, i_pixel, i_red, i_green, i_blue, i_screen,
                                  i_raster_function, i_subwindow_mode, i_font_id,
                                  i_item_handle});
            if (o_valid && !i_stall)
                sb.check_result('{o_status, o_item_out, o_context_index, o_load_all,
                                  o_load_font});
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 20000) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // receiver: random stall per result, one long hold-off on request
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall <= 1;
                repeat (400) @(negedge i_clk);
                long_hold = 0;
            end
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (n > 0) begin
                i_stall <= 1;
                repeat (n - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            i_stall <= 0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    task automatic send_item(t_tb_req r, bit gaps);
        int n;
        n = gaps ? $urandom_range(0, 16) : 0;
        if (n > 0) begin
            i_valid <= 0;
            repeat (n) @(negedge i_clk);
        end
        i_op <= r.op; i_pixel <= r.pixel; i_red <= r.red; i_green <= r.green;
        i_blue <= r.blue; i_screen <= r.screen; i_raster_function <= r.fn;
        i_subwindow_mode <= r.sw; i_font_id <= r.font; i_item_handle <= r.handle;
        i_valid <= 1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    function automatic t_tb_req rand_find();
        t_tb_req r;
        r.op = OP_FIND;
        r.pixel = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 3);
        r.red = 8'($urandom); r.green = 8'($urandom); r.blue = 8'($urandom);
        r.screen = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 1));
        r.fn = 4'($urandom); r.sw = 1'($urandom);
        r.font = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
        r.handle = 7'($urandom);
        return r;
    endfunction

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_tb_req r;
        int      k;
        sb = new();
        sb.clear();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: field extremes, each op, hits, font reload, faults, release, purge
        r = '{OP_FIND, 32'hFFFF_FFFF, 8'hFF, 8'h00, 8'h00, 4'hF, 4'hF, 1'b1,
              32'hFFFF_FFFF, 7'h7F};
        send_item(r, 0);
        send_item(r, 0);
        r.font = 32'h1234_5678; send_item(r, 0);
        r.font = 0; send_item(r, 0);
        r = '{OP_FIND, 32'h0, 8'h0, 8'h0, 8'h0, 4'h0, 4'h0, 1'b0, 32'h0, 7'h0};
        send_item(r, 0);
        send_item(r, 0);
        for (int w = 0; w < 10; w++) begin
            r.pixel = 32'(w + 1); send_item(r, 0);   // fills set 0, then all-miss
        end
        r.op = OP_RELEASE; r.handle = 7'd7; send_item(r, 0);
        r.handle = 7'd7; send_item(r, 0);
        r.handle = 7'h7F; send_item(r, 0);
        r.op = OP_PURGE; send_item(r, 0);
        r.op = 2'd3; send_item(r, 0);
        r.op = OP_FIND; r.pixel = 32'd99; send_item(r, 0);

        // random: mostly finds on few keys to build hits and swaps
        for (k = 0; k < 1700; k++) begin
            if (k == 600) begin
                long_hold = 1;                    // receiver backs up the block
            end
            if (k == 1000) drain();               // sender pauses until all results in
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    r = rand_find(); r.op = OP_RELEASE;
                    r.handle = 7'($urandom);
                end
                3: begin r = rand_find(); r.op = OP_PURGE; end
                4: begin r = rand_find(); r.op = 2'd3; end
                5, 6, 7, 8, 9, 10: begin
                    if (hot.size() > 0) r = hot[$urandom_range(0, hot.size() - 1)];
                    else r = rand_find();
                    if ($urandom_range(0, 1)) r.font = $urandom;
                end
                default: begin
                    r = rand_find();
                    if (hot.size() < 40) hot.push_back(r);
                    else hot[$urandom_range(0, 39)] = r;
                end
            endcase
            send_item(r, (k % 200) < 150);
        end
        i_valid <= 0;
        k = 0;
        while (sb.pending.size() != 0 && k < 100000) begin
            @(negedge i_clk);
            k++;
        end
        repeat (600) @(negedge i_clk);
        if (fail_count == 0 && sb.pending.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
